>>> hw/rtl/isl_pkg.sv
// ----------------------------------------------------------------------------
// isl_pkg: shared definitions for the image source locator
// Widths, character codes, match patterns and the result struct.
// ----------------------------------------------------------------------------
package isl_pkg;

  localparam int POS_BITS = 20;
  localparam int UNIT_BITS = 16;
  localparam int PROG_BITS = 3;

  localparam logic [POS_BITS-1:0] POS_MAX = {POS_BITS{1'b1}};

  localparam logic [UNIT_BITS-1:0] CH_LT     = 16'h003C;
  localparam logic [UNIT_BITS-1:0] CH_GT     = 16'h003E;
  localparam logic [UNIT_BITS-1:0] CH_SPACE  = 16'h0020;
  localparam logic [UNIT_BITS-1:0] CH_DQUOTE = 16'h0022;
  localparam logic [UNIT_BITS-1:0] CH_SQUOTE = 16'h0027;
  localparam logic [UNIT_BITS-1:0] CH_UPPER_A = 16'h0041;
  localparam logic [UNIT_BITS-1:0] CH_UPPER_Z = 16'h005A;
  localparam logic [UNIT_BITS-1:0] CASE_OFFSET = 16'h0020;

  localparam logic [PROG_BITS-1:0] PROG_DONE = 3'd4;

  typedef logic [UNIT_BITS-1:0] unit_t;
  typedef logic [POS_BITS-1:0] pos_t;
  typedef logic [PROG_BITS-1:0] prog_t;
  typedef unit_t pattern_t [4];

  localparam pattern_t TAG_PAT = '{16'h003C, 16'h0069, 16'h006D, 16'h0067};
  localparam pattern_t SRC_PAT = '{16'h0073, 16'h0072, 16'h0063, 16'h003D};

  typedef struct packed {
    logic hit;
    pos_t start;
    pos_t length;
  } result_t;

  function automatic unit_t fold_case(input unit_t c);
    if (c >= CH_UPPER_A && c <= CH_UPPER_Z) begin
      return c + CASE_OFFSET;
    end
    return c;
  endfunction

  function automatic logic is_quote(input unit_t c);
    return (c == CH_DQUOTE) || (c == CH_SQUOTE);
  endfunction

  function automatic prog_t advance(input pattern_t pat, input prog_t prog, input unit_t c);
    if (prog < PROG_DONE && c == pat[prog[1:0]]) begin
      return prog + prog_t'(1);
    end
    return (c == pat[0]) ? prog_t'(1) : prog_t'(0);
  endfunction

endpackage

>>> hw/rtl/isl_if.sv
// ----------------------------------------------------------------------------
// isl_if: stream channels of the image source locator
// One channel for code units in and one for located values out.
// ----------------------------------------------------------------------------
interface isl_in_if;
  logic valid;
  logic ready;
  logic [isl_pkg::UNIT_BITS-1:0] code_unit;
  logic doc_start;

  modport source (output valid, output code_unit, output doc_start, input ready);
  modport sink (input valid, input code_unit, input doc_start, output ready);
endinterface

interface isl_out_if;
  logic valid;
  logic ready;
  logic [isl_pkg::POS_BITS-1:0] value_start;
  logic [isl_pkg::POS_BITS-1:0] value_length;

  modport source (output valid, output value_start, output value_length, input ready);
  modport sink (input valid, input value_start, input value_length, output ready);
endinterface

>>> hw/rtl/isl_core.sv
// ----------------------------------------------------------------------------
// isl_core: tag and attribute matcher
// Tracks the tag and src matches and the value bounds, one unit per step.
// ----------------------------------------------------------------------------
module isl_core (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             step,
  input  isl_pkg::unit_t   unit,
  input  logic             doc_start,
  output isl_pkg::result_t result
);
  import isl_pkg::*;

  prog_t tag_prog_r, tag_prog_nxt;
  logic  inside_r, inside_nxt;
  prog_t src_prog_r, src_prog_nxt;
  logic  src_seen_r, src_seen_nxt;
  logic  await_r, await_nxt;
  pos_t  vbegin_r, vbegin_nxt;
  logic  bquote_r, bquote_nxt;
  logic  efixed_r, efixed_nxt;
  pos_t  vlast_r, vlast_nxt;
  logic  lquote_r, lquote_nxt;
  logic  prevq_r, prevq_nxt;
  pos_t  pos_r, pos_nxt;

  prog_t tag_prog_c, src_prog_c;
  logic  inside_c, src_seen_c, await_c, bquote_c, efixed_c, lquote_c, prevq_c;
  pos_t  vbegin_c, vlast_c, pos_c;

  unit_t c;
  prog_t tag_adv, src_adv;
  pos_t  pos_prev;
  pos_t  close_last;
  logic  close_lq;
  logic [POS_BITS:0] first_u;
  logic signed [POS_BITS+1:0] first_s, last_s, len_s;

  always_comb begin
    if (doc_start) begin
      tag_prog_c = '0;
      inside_c   = 1'b0;
      src_prog_c = '0;
      src_seen_c = 1'b0;
      await_c    = 1'b0;
      vbegin_c   = '0;
      bquote_c   = 1'b0;
      efixed_c   = 1'b0;
      vlast_c    = '0;
      lquote_c   = 1'b0;
      prevq_c    = 1'b0;
      pos_c      = '0;
    end else begin
      tag_prog_c = tag_prog_r;
      inside_c   = inside_r;
      src_prog_c = src_prog_r;
      src_seen_c = src_seen_r;
      await_c    = await_r;
      vbegin_c   = vbegin_r;
      bquote_c   = bquote_r;
      efixed_c   = efixed_r;
      vlast_c    = vlast_r;
      lquote_c   = lquote_r;
      prevq_c    = prevq_r;
      pos_c      = pos_r;
    end
  end

  assign c        = fold_case(unit);
  assign tag_adv  = advance(TAG_PAT, tag_prog_c, c);
  assign src_adv  = advance(SRC_PAT, src_prog_c, c);
  assign pos_prev = (pos_c != '0) ? pos_c - pos_t'(1) : '0;

  assign close_last = efixed_c ? vlast_c : pos_prev;
  assign close_lq   = efixed_c ? lquote_c : prevq_c;
  assign first_u    = {1'b0, vbegin_c} + {{POS_BITS{1'b0}}, bquote_c};
  assign first_s    = $signed({1'b0, first_u});
  assign last_s     = $signed({2'b00, close_last}) - $signed({{(POS_BITS+1){1'b0}}, close_lq});
  assign len_s      = last_s - first_s + $signed({{(POS_BITS+1){1'b0}}, 1'b1});

  always_comb begin
    tag_prog_nxt = tag_prog_c;
    inside_nxt   = inside_c;
    src_prog_nxt = src_prog_c;
    src_seen_nxt = src_seen_c;
    await_nxt    = await_c;
    vbegin_nxt   = vbegin_c;
    bquote_nxt   = bquote_c;
    efixed_nxt   = efixed_c;
    vlast_nxt    = vlast_c;
    lquote_nxt   = lquote_c;
    result.hit    = 1'b0;
    result.start  = first_u[POS_BITS-1:0];
    result.length = len_s[POS_BITS-1:0];

    if (!inside_c) begin
      if (tag_adv == PROG_DONE) begin
        tag_prog_nxt = '0;
        inside_nxt   = 1'b1;
        src_prog_nxt = '0;
        src_seen_nxt = 1'b0;
        await_nxt    = 1'b0;
        vbegin_nxt   = '0;
        bquote_nxt   = 1'b0;
        efixed_nxt   = 1'b0;
        vlast_nxt    = '0;
        lquote_nxt   = 1'b0;
      end else begin
        tag_prog_nxt = tag_adv;
      end
    end else if (c == CH_GT) begin
      result.hit   = src_seen_c && !await_c && (last_s > first_s);
      tag_prog_nxt = '0;
      inside_nxt   = 1'b0;
      src_prog_nxt = '0;
      src_seen_nxt = 1'b0;
      await_nxt    = 1'b0;
      vbegin_nxt   = '0;
      bquote_nxt   = 1'b0;
      efixed_nxt   = 1'b0;
      vlast_nxt    = '0;
      lquote_nxt   = 1'b0;
    end else if (!src_seen_c) begin
      if (src_adv == PROG_DONE) begin
        src_prog_nxt = '0;
        src_seen_nxt = 1'b1;
        await_nxt    = 1'b1;
      end else begin
        src_prog_nxt = src_adv;
      end
    end else begin
      if (await_c) begin
        await_nxt  = 1'b0;
        vbegin_nxt = pos_c;
        bquote_nxt = is_quote(c);
      end
      if (!efixed_c && c == CH_SPACE) begin
        efixed_nxt = 1'b1;
        vlast_nxt  = pos_prev;
        lquote_nxt = prevq_c;
      end
    end

    prevq_nxt = is_quote(unit);
    pos_nxt   = (pos_c == POS_MAX) ? pos_c : pos_c + pos_t'(1);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tag_prog_r <= '0;
      inside_r   <= 1'b0;
      src_prog_r <= '0;
      src_seen_r <= 1'b0;
      await_r    <= 1'b0;
      vbegin_r   <= '0;
      bquote_r   <= 1'b0;
      efixed_r   <= 1'b0;
      vlast_r    <= '0;
      lquote_r   <= 1'b0;
      prevq_r    <= 1'b0;
      pos_r      <= '0;
    end else if (step) begin
      tag_prog_r <= tag_prog_nxt;
      inside_r   <= inside_nxt;
      src_prog_r <= src_prog_nxt;
      src_seen_r <= src_seen_nxt;
      await_r    <= await_nxt;
      vbegin_r   <= vbegin_nxt;
      bquote_r   <= bquote_nxt;
      efixed_r   <= efixed_nxt;
      vlast_r    <= vlast_nxt;
      lquote_r   <= lquote_nxt;
      prevq_r    <= prevq_nxt;
      pos_r      <= pos_nxt;
    end
  end

endmodule

>>> hw/rtl/img_src_locator_top.sv
// ----------------------------------------------------------------------------
// img_src_locator_top: locates src values of img tags in UTF-16 text
// Input register, matcher and result register with a stream handshake.
// ----------------------------------------------------------------------------
// A '>' unit passes the input register and the matcher before its result is held in the result register.
// Throughput: one code unit per cycle, except while the input stage stalls.
// The input stage stalls only while the result register holds an untaken value.
// Reset: rst_n low clears all match state, the position and both stage valids.
module img_src_locator_top (
  input  logic clk,
  input  logic rst_n,
  isl_in_if.sink    in_ch,
  isl_out_if.source out_ch
);
  import isl_pkg::*;

  logic    s1_valid_r, s1_valid_nxt;
  unit_t   s1_unit_r;
  logic    s1_doc_r;
  logic    out_valid_r, out_valid_nxt;
  pos_t    out_start_r;
  pos_t    out_length_r;
  logic    s1_adv;
  logic    in_fire;
  result_t res;

  assign s1_adv      = s1_valid_r && (!out_valid_r || out_ch.ready);
  assign in_ch.ready = !s1_valid_r || s1_adv;
  assign in_fire     = in_ch.valid && in_ch.ready;

  isl_core u_core (
    .clk       (clk),
    .rst_n     (rst_n),
    .step      (s1_adv),
    .unit      (s1_unit_r),
    .doc_start (s1_doc_r),
    .result    (res)
  );

  always_comb begin
    s1_valid_nxt = s1_valid_r;
    if (in_fire) begin
      s1_valid_nxt = 1'b1;
    end else if (s1_adv) begin
      s1_valid_nxt = 1'b0;
    end
    out_valid_nxt = out_valid_r;
    if (s1_adv) begin
      out_valid_nxt = res.hit;
    end else if (out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_unit_r <= in_ch.code_unit;
      s1_doc_r  <= in_ch.doc_start;
    end
    if (s1_adv && res.hit) begin
      out_start_r  <= res.start;
      out_length_r <= res.length;
    end
  end

  assign out_ch.valid        = out_valid_r;
  assign out_ch.value_start  = out_start_r;
  assign out_ch.value_length = out_length_r;

`ifndef ASSERT_OFF
  a_len_min: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid |-> out_ch.value_length >= pos_t'(2))
    else $error("Result transaction with a value shorter than two units.");

  a_hit_lands: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_adv && res.hit) |=> out_valid_r)
    else $error("Matcher result was not captured in the result register.");

  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ch.ready |-> (s1_valid_r && out_valid_r && !out_ch.ready))
    else $error("Input stalled without a blocked result.");
`endif

endmodule
